// File: rtl/gdc_pkg.sv
`default_nettype none

package gdc_pkg;

  // Field widths of the date and of the operation fields.
  localparam int unsigned DayW      = 5;
  localparam int unsigned NewDayW   = 6;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned YearW     = 14;
  localparam int unsigned OpW       = 3;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned Mod25W    = 5;

  // Default for the last year that the counter may hold.
  localparam int unsigned YearMaxDef = 9999;

  // Reciprocal of 25 for the year remainder: q = (y * Recip25) >> Recip25Sh.
  // The rounding error is 12 / 2^19, so the quotient is exact for all 14-bit years.
  localparam int unsigned Recip25W  = 15;
  localparam int unsigned Recip25Sh = 19;
  localparam logic [Recip25W-1:0] Recip25 = Recip25W'(20972);
  localparam int unsigned ProdW     = YearW + Recip25W;
  localparam int unsigned QuotW     = ProdW - Recip25Sh;

  localparam logic [MonthW-1:0] MonthFirst = MonthW'(1);
  localparam logic [MonthW-1:0] MonthLast  = MonthW'(12);
  localparam logic [MonthW-1:0] MonthFeb   = MonthW'(2);
  localparam logic [DayW-1:0]   DayFirst   = DayW'(1);
  localparam logic [DayW-1:0]   DayDec31   = DayW'(31);
  localparam logic [Mod25W-1:0] Mod25Last  = Mod25W'(24);

  typedef enum logic [OpW-1:0] {
    OpRead     = 3'd0,
    OpSetDay   = 3'd1,
    OpSetMonth = 3'd2,
    OpSetYear  = 3'd3,
    OpSetDate  = 3'd4,
    OpNext     = 3'd5,
    OpPrev     = 3'd6
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StMonthBig   = 3'd1,
    StMonthSmall = 3'd2,
    StDaySmall   = 3'd3,
    StDayBig     = 3'd4,
    StYearRange  = 3'd5
  } status_e;

  // Stored date together with the year's remainder modulo 25.
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [Mod25W-1:0] ym25;
  } date_t;

  // Remainder of a year modulo 25 by reciprocal multiplication.
  function automatic logic [Mod25W-1:0] year_mod25(input logic [YearW-1:0] y);
    logic [ProdW-1:0] prod;
    logic [QuotW-1:0] q;
    logic [YearW-1:0] qx25;
    prod = ProdW'(y) * ProdW'(Recip25);
    q    = prod[ProdW-1:Recip25Sh];
    qx25 = YearW'({q, 4'b0000}) + YearW'({q, 3'b000}) + YearW'(q);
    return Mod25W'(y - qx25);
  endfunction

  // Leap year: divisible by 4, and not by 100 unless also by 400.
  // With the remainder modulo 25 known, 100 and 400 reduce to bit tests.
  function automatic logic is_leap(input logic [YearW-1:0] y,
                                   input logic [Mod25W-1:0] m25);
    return (y[1:0] == 2'b00) && !((m25 == '0) && (y[3:0] != 4'b0000));
  endfunction

  // Number of days in a month; months outside 1..12 give 31.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      MonthFeb:                             len = leap ? DayW'(29) : DayW'(28);
      MonthW'(4), MonthW'(6), MonthW'(9),
      MonthW'(11):                          len = DayW'(30);
      default:                              len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gdc_in_if.sv
`default_nettype none

interface gdc_in_if;
  logic                             valid;
  logic                             ready;
  logic [gdc_pkg::OpW-1:0]          op;
  logic [gdc_pkg::NewDayW-1:0]      new_day;
  logic [gdc_pkg::MonthW-1:0]       new_month;
  logic [gdc_pkg::YearW-1:0]        new_year;

  modport source (output valid, output op, output new_day, output new_month,
                  output new_year, input ready);
  modport sink   (input valid, input op, input new_day, input new_month,
                  input new_year, output ready);
endinterface

`default_nettype wire

// File: rtl/gdc_out_if.sv
`default_nettype none

interface gdc_out_if;
  logic                          valid;
  logic                          ready;
  logic [gdc_pkg::DayW-1:0]      cur_day;
  logic [gdc_pkg::MonthW-1:0]    cur_month;
  logic [gdc_pkg::YearW-1:0]     cur_year;
  logic [gdc_pkg::StatusW-1:0]   status;

  modport source (output valid, output cur_day, output cur_month, output cur_year,
                  output status, input ready);
  modport sink   (input valid, input cur_day, input cur_month, input cur_year,
                  input status, output ready);
endinterface

`default_nettype wire

// File: rtl/gregorian_date_counter.sv
// An accepted transfer goes into the input register and from there into the result register.
// Throughput: one operation per cycle unless the output stalls; the stored date is read and
// written back in the same cycle. A waiting result still lets one item into the input register.
// Reset (asynchronous, active low) sets the date to January 1 of year 1 and empties both stages.
`default_nettype none

module gregorian_date_counter #(
  parameter int unsigned YEAR_MAX = gdc_pkg::YearMaxDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdc_in_if.sink    in_i,
  gdc_out_if.source out_o
);

  // Input stage.
  logic                            s1_valid_q;
  gdc_pkg::op_e                    s1_op_q;
  logic [gdc_pkg::NewDayW-1:0]     s1_day_q;
  logic [gdc_pkg::MonthW-1:0]      s1_month_q;
  logic [gdc_pkg::YearW-1:0]       s1_year_q;
  logic [gdc_pkg::Mod25W-1:0]      s1_m25_q;

  // Stored date and result stage.
  gdc_pkg::date_t                  date_q;
  gdc_pkg::date_t                  date_d;
  gdc_pkg::status_e                status_d;
  logic                            out_valid_q;
  logic [gdc_pkg::DayW-1:0]        out_day_q;
  logic [gdc_pkg::MonthW-1:0]      out_month_q;
  logic [gdc_pkg::YearW-1:0]       out_year_q;
  gdc_pkg::status_e                out_status_q;

  logic                            advance;
  logic                            in_fire;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  // Input register; the year remainder modulo 25 is taken on the way in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= gdc_pkg::op_e'(in_i.op);
      s1_day_q   <= in_i.new_day;
      s1_month_q <= in_i.new_month;
      s1_year_q  <= in_i.new_year;
      s1_m25_q   <= gdc_pkg::year_mod25(in_i.new_year);
    end
  end

  gdc_exec #(
    .YEAR_MAX (YEAR_MAX)
  ) u_exec (
    .cur_i       (date_q),
    .op_i        (s1_op_q),
    .new_day_i   (s1_day_q),
    .new_month_i (s1_month_q),
    .new_year_i  (s1_year_q),
    .new_m25_i   (s1_m25_q),
    .nxt_o       (date_d),
    .status_o    (status_d)
  );

  // Date register, written when an item moves into the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_q.day   <= gdc_pkg::DayFirst;
      date_q.month <= gdc_pkg::MonthFirst;
      date_q.year  <= gdc_pkg::YearW'(1);
      date_q.ym25  <= gdc_pkg::Mod25W'(1);
    end else if (advance) begin
      date_q <= date_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_day_q    <= date_d.day;
      out_month_q  <= date_d.month;
      out_year_q   <= date_d.year;
      out_status_q <= status_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cur_day   = out_day_q;
  assign out_o.cur_month = out_month_q;
  assign out_o.cur_year  = out_year_q;
  assign out_o.status    = out_status_q;

`ifndef ASSERT_OFF
  // The stored date is always a real calendar date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (date_q.month >= gdc_pkg::MonthFirst) && (date_q.month <= gdc_pkg::MonthLast) &&
    (date_q.day >= gdc_pkg::DayFirst) &&
    (date_q.day <= gdc_pkg::month_len(date_q.month,
                                      gdc_pkg::is_leap(date_q.year, date_q.ym25))))
    else $error("stored date is not a valid calendar date");

  // The stored year never passes the configured maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    date_q.year <= gdc_pkg::YearW'(YEAR_MAX))
    else $error("stored year above maximum");

  // The tracked remainder modulo 25 follows the stored year through steps and sets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    date_q.ym25 == gdc_pkg::year_mod25(date_q.year))
    else $error("year remainder out of step with year");

  // The date changes only when an item moves into the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(date_q))
    else $error("date changed without an item");
`endif

endmodule

`default_nettype wire

// File: rtl/gdc_exec.sv
`default_nettype none

// Applies one operation to the stored date and gives the next date and status.
module gdc_exec #(
  parameter int unsigned YEAR_MAX = gdc_pkg::YearMaxDef
) (
  input  gdc_pkg::date_t                 cur_i,
  input  gdc_pkg::op_e                   op_i,
  input  logic [gdc_pkg::NewDayW-1:0]    new_day_i,
  input  logic [gdc_pkg::MonthW-1:0]     new_month_i,
  input  logic [gdc_pkg::YearW-1:0]      new_year_i,
  input  logic [gdc_pkg::Mod25W-1:0]     new_m25_i,
  output gdc_pkg::date_t                 nxt_o,
  output gdc_pkg::status_e               status_o
);

  localparam logic [gdc_pkg::YearW-1:0] YearMax = gdc_pkg::YearW'(YEAR_MAX);

  logic                            leap_cur;
  logic                            leap_new;
  logic [gdc_pkg::DayW-1:0]        len_cur;
  logic [gdc_pkg::MonthW-1:0]      month_dec;
  logic [gdc_pkg::DayW-1:0]        len_prev;

  // Candidate date of a set operation.
  logic                            is_set;
  logic [gdc_pkg::NewDayW-1:0]     cd;
  logic [gdc_pkg::MonthW-1:0]      cm;
  logic [gdc_pkg::YearW-1:0]       cy;
  logic [gdc_pkg::Mod25W-1:0]      cm25;
  logic                            cleap;
  gdc_pkg::status_e                set_st;

  assign leap_cur  = gdc_pkg::is_leap(cur_i.year, cur_i.ym25);
  assign leap_new  = gdc_pkg::is_leap(new_year_i, new_m25_i);
  assign len_cur   = gdc_pkg::month_len(cur_i.month, leap_cur);
  assign month_dec = cur_i.month - gdc_pkg::MonthW'(1);
  assign len_prev  = gdc_pkg::month_len(month_dec, leap_cur);

  // Build the candidate from the new parts and the stored parts.
  always_comb begin
    is_set = 1'b1;
    cd     = {1'b0, cur_i.day};
    cm     = cur_i.month;
    cy     = cur_i.year;
    cm25   = cur_i.ym25;
    cleap  = leap_cur;
    case (op_i)
      gdc_pkg::OpSetDay: begin
        cd = new_day_i;
      end
      gdc_pkg::OpSetMonth: begin
        cm = new_month_i;
      end
      gdc_pkg::OpSetYear: begin
        cy    = new_year_i;
        cm25  = new_m25_i;
        cleap = leap_new;
      end
      gdc_pkg::OpSetDate: begin
        cd    = new_day_i;
        cm    = new_month_i;
        cy    = new_year_i;
        cm25  = new_m25_i;
        cleap = leap_new;
      end
      default: begin
        is_set = 1'b0;
      end
    endcase
  end

  // Checks in priority order; the first one that fails gives the status.
  always_comb begin
    if (cm > gdc_pkg::MonthLast) begin
      set_st = gdc_pkg::StMonthBig;
    end else if (cm == '0) begin
      set_st = gdc_pkg::StMonthSmall;
    end else if (cd == '0) begin
      set_st = gdc_pkg::StDaySmall;
    end else if (cd > {1'b0, gdc_pkg::month_len(cm, cleap)}) begin
      set_st = gdc_pkg::StDayBig;
    end else if (cy > YearMax) begin
      set_st = gdc_pkg::StYearRange;
    end else begin
      set_st = gdc_pkg::StOk;
    end
  end

  // Next date for sets and for day steps.
  always_comb begin
    nxt_o    = cur_i;
    status_o = gdc_pkg::StOk;
    if (is_set) begin
      status_o = set_st;
      if (set_st == gdc_pkg::StOk) begin
        nxt_o.day   = cd[gdc_pkg::DayW-1:0];
        nxt_o.month = cm;
        nxt_o.year  = cy;
        nxt_o.ym25  = cm25;
      end
    end else if (op_i == gdc_pkg::OpNext) begin
      if (cur_i.day < len_cur) begin
        nxt_o.day = cur_i.day + gdc_pkg::DayW'(1);
      end else if (cur_i.month < gdc_pkg::MonthLast) begin
        nxt_o.month = cur_i.month + gdc_pkg::MonthW'(1);
        nxt_o.day   = gdc_pkg::DayFirst;
      end else if (cur_i.year >= YearMax) begin
        status_o = gdc_pkg::StYearRange;
      end else begin
        nxt_o.year  = cur_i.year + gdc_pkg::YearW'(1);
        nxt_o.month = gdc_pkg::MonthFirst;
        nxt_o.day   = gdc_pkg::DayFirst;
        nxt_o.ym25  = (cur_i.ym25 == gdc_pkg::Mod25Last) ? '0
                                                         : cur_i.ym25 + gdc_pkg::Mod25W'(1);
      end
    end else if (op_i == gdc_pkg::OpPrev) begin
      if (cur_i.day > gdc_pkg::DayFirst) begin
        nxt_o.day = cur_i.day - gdc_pkg::DayW'(1);
      end else if (cur_i.month > gdc_pkg::MonthFirst) begin
        nxt_o.month = month_dec;
        nxt_o.day   = len_prev;
      end else if (cur_i.year == '0) begin
        status_o = gdc_pkg::StYearRange;
      end else begin
        nxt_o.year  = cur_i.year - gdc_pkg::YearW'(1);
        nxt_o.month = gdc_pkg::MonthLast;
        nxt_o.day   = gdc_pkg::DayDec31;
        nxt_o.ym25  = (cur_i.ym25 == '0) ? gdc_pkg::Mod25Last
                                         : cur_i.ym25 - gdc_pkg::Mod25W'(1);
      end
    end
  end

endmodule

`default_nettype wire
